[design/primary_backup_election_assert.svh]
// Assertion macros used by the election block's checker.
`ifndef PRIMARY_BACKUP_ELECTION_ASSERT_SVH
`define PRIMARY_BACKUP_ELECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/pbe_pkg.sv]
// Types and constants of the primary/backup election block.
`default_nettype none

package pbe_pkg;

  typedef enum logic [1:0] {
    ROLE_LISTEN  = 2'd0,
    ROLE_RAISE   = 2'd1,
    ROLE_PRIMARY = 2'd2,
    ROLE_DISABLE = 2'd3
  } role_e;

  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_MSG  = 2'd1;
  localparam logic [1:0] REQ_DATA = 2'd2;

  localparam logic [1:0] MSG_REQUEST = 2'd0;
  localparam logic [1:0] MSG_REPLY   = 2'd1;

  localparam logic SEND_REQUEST = 1'b0;
  localparam logic SEND_REPLY   = 1'b1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_GROUP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_INSTANCE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLE = 3'd4;

  localparam logic [8:0] IDLE_MAX   = 9'd511;
  localparam logic [2:0] MON_LIMIT  = 3'd6;
  localparam logic [7:0] NO_PRIMARY = 8'd255;
  localparam logic [7:0] IDLE_LIMIT_RESET = 8'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [1:0]  msg_kind;
    logic [15:0] sender_group;
    logic [7:0]  sender_instance;
    logic [7:0]  reply_target;
  } pbe_in_t;

  typedef struct packed {
    logic        send_valid;
    logic        send_kind;
    logic [7:0]  send_target;
    logic [1:0]  arb_status;
    logic [7:0]  known_primary;
  } pbe_out_t;

endpackage

`default_nettype wire

[design/pbe_elect.sv]
// Election state, configuration registers and per-word next-state logic.
`default_nettype none

module pbe_elect (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [pbe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [pbe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                fire_i,
  input  wire pbe_pkg::pbe_in_t                    item_i,
  output pbe_pkg::pbe_out_t                        res_o
);

  logic [15:0]     own_group_q, own_group_d;
  logic [7:0]      own_inst_q, own_inst_d;
  logic [7:0]      idle_limit_q, idle_limit_d;
  logic            prim_en_q, prim_en_d;
  logic            mon_en_q, mon_en_d;

  pbe_pkg::role_e  role_q, role_d;
  logic [7:0]      seen_q, seen_d;
  logic [8:0]      idle_q, idle_d;
  logic [2:0]      mon_cnt_q, mon_cnt_d;

  logic            send_valid, send_kind;
  logic [7:0]      send_target;
  logic            own_grp, mon_drop;

  assign own_grp  = (item_i.sender_group == own_group_q);
  assign mon_drop = mon_en_q && (mon_cnt_q > pbe_pkg::MON_LIMIT)
                    && (item_i.sender_instance == seen_q);

  always_comb begin
    own_group_d  = own_group_q;
    own_inst_d   = own_inst_q;
    idle_limit_d = idle_limit_q;
    prim_en_d    = prim_en_q;
    mon_en_d     = mon_en_q;
    role_d       = role_q;
    seen_d       = seen_q;
    idle_d       = idle_q;
    mon_cnt_d    = mon_cnt_q;
    send_valid   = 1'b0;
    send_kind    = pbe_pkg::SEND_REQUEST;
    send_target  = 8'd0;

    if (fire_i) begin
      case (item_i.req_type)
        pbe_pkg::REQ_TICK: begin
          if (prim_en_q) begin
            if (role_q != pbe_pkg::ROLE_PRIMARY) begin
              if (idle_q < pbe_pkg::IDLE_MAX) begin
                idle_d = idle_q + 9'd1;
              end
              if (idle_d > {1'b0, idle_limit_q}) begin
                role_d     = pbe_pkg::ROLE_RAISE;
                send_valid = 1'b1;
              end
            end else begin
              send_valid  = 1'b1;
              send_kind   = pbe_pkg::SEND_REPLY;
              send_target = own_inst_q;
            end
          end
        end
        pbe_pkg::REQ_MSG: begin
          if (own_grp && !mon_drop) begin
            idle_d = 9'd0;
            if (role_q == pbe_pkg::ROLE_LISTEN) begin
              if (item_i.msg_kind == pbe_pkg::MSG_REPLY) begin
                seen_d = item_i.sender_instance;
                if (mon_en_q && (mon_cnt_q <= pbe_pkg::MON_LIMIT)) begin
                  mon_cnt_d = mon_cnt_q + 3'd1;
                end
              end
            end else if (item_i.msg_kind == pbe_pkg::MSG_REPLY) begin
              role_d = (item_i.reply_target == own_inst_q) ? pbe_pkg::ROLE_PRIMARY
                                                           : pbe_pkg::ROLE_LISTEN;
            end else if (item_i.msg_kind == pbe_pkg::MSG_REQUEST) begin
              if (item_i.sender_instance == own_inst_q) begin
                send_valid  = 1'b1;
                send_kind   = pbe_pkg::SEND_REPLY;
                send_target = item_i.sender_instance;
              end
            end else begin
              role_d = pbe_pkg::ROLE_LISTEN;
            end
          end
        end
        pbe_pkg::REQ_DATA: begin
          if (own_grp) begin
            if (item_i.sender_instance != own_inst_q) begin
              role_d = pbe_pkg::ROLE_LISTEN;
            end
            mon_cnt_d = 3'd0;
          end
        end
        default: begin
        end
      endcase
    end

    // The user must issue register writes only while the block is idle; the block does not enforce this.
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pbe_pkg::CFG_OWN_GROUP:    own_group_d  = cfg_data_i;
        pbe_pkg::CFG_OWN_INSTANCE: own_inst_d   = cfg_data_i[7:0];
        pbe_pkg::CFG_IDLE_LIMIT:   idle_limit_d = cfg_data_i[7:0];
        pbe_pkg::CFG_PRIMARY_ENABLE: begin
          if (!cfg_data_i[0]) begin
            role_d    = pbe_pkg::ROLE_DISABLE;
            prim_en_d = 1'b0;
          end else if (!prim_en_q) begin
            role_d    = pbe_pkg::ROLE_LISTEN;
            prim_en_d = 1'b1;
          end
        end
        pbe_pkg::CFG_MONITOR_ENABLE: begin
          mon_cnt_d = 3'd0;
          mon_en_d  = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_group_q  <= 16'd0;
      own_inst_q   <= 8'd0;
      idle_limit_q <= pbe_pkg::IDLE_LIMIT_RESET;
      prim_en_q    <= 1'b1;
      mon_en_q     <= 1'b0;
      role_q       <= pbe_pkg::ROLE_LISTEN;
      seen_q       <= pbe_pkg::NO_PRIMARY;
      idle_q       <= 9'd0;
      mon_cnt_q    <= 3'd0;
    end else begin
      own_group_q  <= own_group_d;
      own_inst_q   <= own_inst_d;
      idle_limit_q <= idle_limit_d;
      prim_en_q    <= prim_en_d;
      mon_en_q     <= mon_en_d;
      role_q       <= role_d;
      seen_q       <= seen_d;
      idle_q       <= idle_d;
      mon_cnt_q    <= mon_cnt_d;
    end
  end

  assign res_o.send_valid    = send_valid;
  assign res_o.send_kind     = send_kind;
  assign res_o.send_target   = send_target;
  assign res_o.arb_status    = role_d;
  assign res_o.known_primary = seen_d;

endmodule

`default_nettype wire

[design/primary_backup_election.sv]
// Throughput: one word per cycle while the output is not stalled; the input
// register frees in the cycle it hands its word to the election logic, the
// result register parts the sides.
// Reset (async, active low): roles listen, no known primary, counters zero,
// registers at their reset values, both pipeline stages empty.
// Top level: input register, election logic, result register.
`default_nettype none

module primary_backup_election (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire pbe_pkg::pbe_in_t                in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output pbe_pkg::pbe_out_t                    out_data_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [pbe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pbe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  // Input stage: hold the accepted word until the result register can take
  // its result.
  logic              in_valid_q;
  pbe_pkg::pbe_in_t  in_data_q;
  // Result stage.
  logic              out_valid_q;
  pbe_pkg::pbe_out_t out_data_q;

  logic              advance;
  pbe_pkg::pbe_out_t res;

  // Advance when the input stage holds a word and the result slot is free
  // or is being drained in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Word-driven state updates happen exactly when a word advances (register
  // writes act apart from that), so each word sees the state left by its predecessor.
  pbe_elect u_elect (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (advance),
    .item_i     (in_data_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Load a new word only on acceptance; otherwise hold.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[design/pbe_checker.sv]
// Port-level checker for the election block and its bind.
`default_nettype none
`include "primary_backup_election_assert.svh"

module pbe_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire pbe_pkg::pbe_out_t out_data_o
);

  `PBE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o), "result word changed while stalled")

  `PBE_ASSERT_NOW(a_ready_only_on_stall, clk_i, rst_ni, !in_ready_o,
    out_valid_o && !out_ready_i, "input stalled without output backpressure")

  `PBE_ASSERT_NOW(a_quiet_fields, clk_i, rst_ni,
    out_valid_o && !out_data_o.send_valid,
    out_data_o.send_kind == pbe_pkg::SEND_REQUEST && out_data_o.send_target == 8'd0,
    "send fields set without a message")

  `PBE_ASSERT_NOW(a_request_raises, clk_i, rst_ni,
    out_valid_o && out_data_o.send_valid && out_data_o.send_kind == pbe_pkg::SEND_REQUEST,
    out_data_o.arb_status == pbe_pkg::ROLE_RAISE && out_data_o.send_target == 8'd0,
    "request sent outside raise-hand")

endmodule

bind primary_backup_election pbe_checker u_pbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
